[design/nnc_pkg.sv]
// Package with shared types and constants of the nearest neighbour classifier.
`default_nettype none
package nnc_pkg;
    localparam int SQ_W   = 36;
    localparam int ROOT_W = 18;
    localparam int FEAT_W = 16;
    localparam int LBL_W  = 8;
    localparam int CONF_W = 16;
    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [0:0] REG_ENTRIES = 1'b0;

    typedef struct packed {
        logic [SQ_W-1:0]  nearest;
        logic [SQ_W-1:0]  second;
        logic [LBL_W-1:0] label;
        logic             found;
        logic             multi;
    } scan_result_t;
endpackage
`default_nettype wire

[design/nnc_isqrt.sv]
// Iterative integer square root, two radicand bits per step, one result bit per cycle.
`default_nettype none
module nnc_isqrt (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [nnc_pkg::SQ_W-1:0]      radicand,
    output logic                         done,
    output logic [nnc_pkg::ROOT_W-1:0]   root
);
    import nnc_pkg::*;
    logic [SQ_W+1:0]   rem_reg;
    logic [SQ_W-1:0]   x_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic [SQ_W+1:0]   trial;
    logic [SQ_W+1:0]   rem_sh;

    assign rem_sh = {rem_reg[SQ_W-1:0], x_reg[SQ_W-1:SQ_W-2]};
    assign trial  = rem_sh - {{(SQ_W-ROOT_W){1'b0}}, q_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                x_reg    <= radicand;
                q_reg    <= '0;
                cnt_reg  <= 5'(ROOT_W - 1);
            end else if (busy_reg) begin
                x_reg <= {x_reg[SQ_W-3:0], 2'b00};
                if (!trial[SQ_W+1]) begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign root = q_reg;
endmodule
`default_nettype wire

[design/nnc_divider.sv]
// Restoring divider giving the Q0.16 confidence quotient, one bit per cycle.
`default_nettype none
module nnc_divider (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [nnc_pkg::ROOT_W-1:0]    d1,
    input  wire [nnc_pkg::ROOT_W-1:0]    d2,
    output logic                         done,
    output logic [nnc_pkg::CONF_W-1:0]   quotient
);
    import nnc_pkg::*;
    localparam int NW = ROOT_W + CONF_W;
    localparam int DW = ROOT_W + 1;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] q_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    assign rem_sh = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                num_reg  <= {d2, {CONF_W{1'b0}}};
                den_reg  <= {1'b0, d1} + {1'b0, d2};
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= 6'(NW - 1);
            end else if (busy_reg) begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                if (!diff[DW]) begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[NW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign quotient = (|q_reg[NW-1:CONF_W]) ? {CONF_W{1'b1}} : q_reg[CONF_W-1:0];
endmodule
`default_nettype wire

[design/nnc_scan.sv]
// Reference memories and the distance scan that keeps the two nearest squares.
`default_nettype none
module nnc_scan #(
    parameter int MAX_ENTRIES   = 64,
    parameter int FEATURE_COUNT = 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              wr_en,
    input  wire [$clog2(MAX_ENTRIES)-1:0]    wr_entry,
    input  wire [2:0]                        wr_feat,
    input  wire [nnc_pkg::FEAT_W-1:0]        wr_value,
    input  wire [nnc_pkg::LBL_W-1:0]         wr_label,
    input  wire                              q_en,
    input  wire [2:0]                        q_feat,
    input  wire [nnc_pkg::FEAT_W-1:0]        q_value,
    input  wire                              start,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]  count,
    output logic                             done,
    output nnc_pkg::scan_result_t            result
);
    import nnc_pkg::*;
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH = MAX_ENTRIES * FEATURE_COUNT;
    localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;

    logic [FEAT_W-1:0] feat_mem [DEPTH];
    logic [LBL_W-1:0]  lbl_mem [MAX_ENTRIES];
    logic [FEAT_W-1:0] query_reg [FEATURE_COUNT];

    logic [FEAT_W-1:0] rd_feat_reg;
    logic [LBL_W-1:0]  rd_lbl_reg;
    logic [EW-1:0]     rd_entry;
    logic [FW-1:0]     rd_f;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;
    state_t          state_reg;
    logic [CW-1:0]   e_reg;
    logic [FW-1:0]   f_reg;
    logic            v1_reg, last1_reg;
    logic [FW-1:0]   f1_reg;
    logic [CW-1:0]   e1_reg;
    logic            v2_reg, last2_reg;
    logic [CW-1:0]   e2_reg;
    logic [LBL_W-1:0] lbl2_reg;
    logic [2*FEAT_W:0] sq2_reg;
    logic [SQ_W-1:0] sum_reg;
    logic [SQ_W-1:0] near_reg, sec_reg;
    logic [LBL_W-1:0] nlbl_reg;
    logic [CW-1:0]   cnt_reg;

    logic signed [FEAT_W:0] diff;
    logic [FEAT_W:0]        adiff;
    logic [SQ_W:0]          acc;
    logic [SQ_W-1:0]        acc_sat;

    assign wr_addr = AW'(wr_entry * FEATURE_COUNT + 32'(wr_feat));
    assign rd_entry = e_reg[EW-1:0];
    assign rd_f     = f_reg;
    assign rd_addr  = AW'(rd_entry * FEATURE_COUNT + 32'(rd_f));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (32'(wr_feat) < FEATURE_COUNT) feat_mem[wr_addr] <= wr_value;
            lbl_mem[wr_entry] <= wr_label;
        end
        rd_feat_reg <= feat_mem[rd_addr];
        rd_lbl_reg  <= lbl_mem[rd_entry];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FEATURE_COUNT; i++) query_reg[i] <= '0;
        end else if (q_en && 32'(q_feat) < FEATURE_COUNT) begin
            query_reg[FW'(q_feat)] <= q_value;
        end
    end

    assign diff  = $signed({query_reg[f1_reg][FEAT_W-1], query_reg[f1_reg]})
                 - $signed({rd_feat_reg[FEAT_W-1], rd_feat_reg});
    assign adiff = diff[FEAT_W] ? $unsigned(-diff) : $unsigned(diff);
    assign acc     = {1'b0, sum_reg} + (SQ_W+1)'(sq2_reg);
    assign acc_sat = acc[SQ_W] ? SQ_MAX : acc[SQ_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done      <= 1'b0;
            e_reg     <= '0;
            f_reg     <= '0;
            sum_reg   <= '0;
            near_reg  <= SQ_MAX;
            sec_reg   <= SQ_MAX;
            nlbl_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            done   <= 1'b0;
            v1_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        near_reg <= SQ_MAX;
                        sec_reg  <= SQ_MAX;
                        nlbl_reg <= '0;
                        sum_reg  <= '0;
                        cnt_reg  <= count;
                        e_reg    <= '0;
                        f_reg    <= '0;
                        state_reg <= (count == '0) ? S_DRAIN : S_RUN;
                    end
                end
                S_RUN: begin
                    v1_reg    <= 1'b1;
                    f1_reg    <= f_reg;
                    e1_reg    <= e_reg;
                    last1_reg <= (32'(f_reg) == FEATURE_COUNT - 1);
                    if (32'(f_reg) == FEATURE_COUNT - 1) begin
                        f_reg <= '0;
                        e_reg <= e_reg + CW'(1);
                        if (e_reg + CW'(1) == cnt_reg) state_reg <= S_DRAIN;
                    end else begin
                        f_reg <= f_reg + FW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!v1_reg && !v2_reg) begin
                        done      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            e2_reg    <= e1_reg;
            lbl2_reg  <= rd_lbl_reg;
            sq2_reg   <= (2*FEAT_W+1)'(adiff * adiff);
            if (v2_reg) begin
                if (last2_reg) begin
                    sum_reg <= '0;
                    if (e2_reg == '0 || acc_sat < near_reg) begin
                        sec_reg  <= near_reg;
                        near_reg <= acc_sat;
                        nlbl_reg <= lbl2_reg;
                    end else if (e2_reg == CW'(1) || acc_sat < sec_reg) begin
                        sec_reg <= acc_sat;
                    end
                end else begin
                    sum_reg <= acc_sat;
                end
            end
        end
    end

    assign result.nearest = near_reg;
    assign result.second  = sec_reg;
    assign result.label   = nlbl_reg;
    assign result.found   = (cnt_reg != '0);
    assign result.multi   = (cnt_reg > CW'(1));
endmodule
`default_nettype wire

[design/nearest_neighbor_classifier.sv]
// Top level of the nearest neighbour classifier.
// A store or non-final query beat is accepted whenever the block is idle.
// A final query beat starts the memory scan, then the square root of the nearest distance,
// of the second one if two or more entries are in use, and the divide unless both roots are zero; one query at a time.
// The result sits in an output register until taken.
// Reset is synchronous, active low, and clears the control state and the query vector.
`default_nettype none
module nearest_neighbor_classifier #(
    parameter int MAX_ENTRIES   = 64,
    parameter int FEATURE_COUNT = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_operation,
    input  wire  [5:0]  s_entry_index,
    input  wire  [2:0]  s_feature_index,
    input  wire  signed [15:0] s_feature_value,
    input  wire  [7:0]  s_label_id,
    input  wire         s_last,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_best_label,
    output logic [17:0] m_best_distance,
    output logic [15:0] m_confidence,
    output logic        m_found
);
    import nnc_pkg::*;
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {T_IDLE, T_SCAN, T_ROOT1, T_ROOT2, T_DIV, T_OUT} top_state_t;
    top_state_t state_reg;
    logic [6:0] entries_reg;
    logic [CW-1:0] count;
    logic s_fire, store_fire, query_fire, search;
    logic scan_done, root_done, div_done, root_start, div_start;
    logic [SQ_W-1:0] root_in;
    logic [ROOT_W-1:0] root, d1_reg, d2_reg;
    logic [CONF_W-1:0] quot;
    scan_result_t res;
    logic [EW-1:0] wr_entry;
    logic wr_ok;

    assign pready = 1'b1;
    assign prdata = {25'd0, entries_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) entries_reg <= '0;
        else if (psel && penable && pwrite && paddr[1] == REG_ENTRIES) entries_reg <= pwdata[6:0];
    end

    assign count = (32'(entries_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entries_reg);
    assign s_ready    = (state_reg == T_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign wr_ok      = (32'(s_entry_index) < MAX_ENTRIES);
    assign wr_entry   = EW'(s_entry_index);
    assign store_fire = s_fire && s_operation == OP_STORE && wr_ok;
    assign query_fire = s_fire && s_operation == OP_QUERY;
    assign search     = query_fire && s_last;

    nnc_scan #(.MAX_ENTRIES(MAX_ENTRIES), .FEATURE_COUNT(FEATURE_COUNT)) u_scan (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(store_fire), .wr_entry(wr_entry), .wr_feat(s_feature_index),
        .wr_value(s_feature_value), .wr_label(s_label_id),
        .q_en(query_fire), .q_feat(s_feature_index), .q_value(s_feature_value),
        .start(search), .count(count), .done(scan_done), .result(res)
    );

    assign root_start = (state_reg == T_SCAN && scan_done)
                     || (state_reg == T_ROOT1 && root_done && res.multi);
    assign root_in = (state_reg == T_SCAN) ? res.nearest : res.second;
    nnc_isqrt u_isqrt (.aclk(aclk), .aresetn(aresetn), .start(root_start),
                       .radicand(root_in), .done(root_done), .root(root));

    assign div_start = (state_reg == T_ROOT2 && root_done && (d1_reg != '0 || root != '0));
    nnc_divider u_div (.aclk(aclk), .aresetn(aresetn), .start(div_start),
                       .d1(d1_reg), .d2(root), .done(div_done), .quotient(quot));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            m_valid   <= 1'b0;
        end else begin
            case (state_reg)
                T_IDLE: if (search) state_reg <= T_SCAN;
                T_SCAN: begin
                    if (scan_done) begin
                        if (!res.found) begin
                            m_best_label    <= '0;
                            m_best_distance <= '0;
                            m_confidence    <= '1;
                            m_found         <= 1'b0;
                            m_valid         <= 1'b1;
                            state_reg       <= T_OUT;
                        end else begin
                            state_reg <= T_ROOT1;
                        end
                    end
                end
                T_ROOT1: begin
                    if (root_done) begin
                        d1_reg          <= root;
                        m_best_label    <= res.label;
                        m_best_distance <= root;
                        m_found         <= 1'b1;
                        if (res.multi) begin
                            state_reg <= T_ROOT2;
                        end else begin
                            m_confidence <= '1;
                            m_valid      <= 1'b1;
                            state_reg    <= T_OUT;
                        end
                    end
                end
                T_ROOT2: begin
                    if (root_done) begin
                        if (d1_reg == '0 && root == '0) begin
                            m_confidence <= 16'h8000;
                            m_valid      <= 1'b1;
                            state_reg    <= T_OUT;
                        end else begin
                            state_reg <= T_DIV;
                        end
                    end
                end
                T_DIV: begin
                    if (div_done) begin
                        m_confidence <= quot;
                        m_valid      <= 1'b1;
                        state_reg    <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    a_valid_only_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == T_OUT) else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != T_IDLE) |-> !s_ready) else $error("input accepted during search");
    a_search_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        search |=> state_reg == T_SCAN) else $error("search did not start");
endmodule
`default_nettype wire
